[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the deque engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/bldq_pkg.sv]
// Shared types and constants for the bounded list deque engine.
// No dependencies.
`default_nettype none

package bldq_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int LEN_W  = 5;

  localparam logic [WORD_W-1:0] NEG_ONE = '1;

  // Operation codes; code 7 is a no-op
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4,
    OP_CONTAINS   = 3'd5,
    OP_SORT       = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SORT_START,
    S_WALK,
    S_FLUSH,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;      // latch the incoming request
    logic pop_read;     // read the end word for a pop
    logic walk_start;   // clear walk counters, set walk limit
    logic walk_run;     // advance the read/compare/write walk
    logic sort_init;    // set last index of the first bubble pass
    logic sort_flush;   // write the carried max, shrink the pass
    logic result_load;  // commit the request and load the result
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic empty;
    logic few;          // fewer than two entries
    logic last_pass;
    logic walk_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/bldq_ctrl.sv]
// Controller state machine for the bounded list deque engine.
// Depends on bldq_pkg.
`default_nettype none

module bldq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire bldq_pkg::dp_stat_t stat,
  output bldq_pkg::dp_cmd_t       cmd
);

  bldq_pkg::state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bldq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bldq_pkg::S_IDLE: begin
        if (in_valid) state_next = bldq_pkg::S_DECODE;
      end
      bldq_pkg::S_DECODE: begin
        case (stat.op) inside
          bldq_pkg::OP_DELETE, bldq_pkg::OP_CONTAINS: state_next = bldq_pkg::S_WALK;
          bldq_pkg::OP_SORT: begin
            state_next = stat.few ? bldq_pkg::S_DONE : bldq_pkg::S_SORT_START;
          end
          default: state_next = bldq_pkg::S_DONE;
        endcase
      end
      bldq_pkg::S_SORT_START: state_next = bldq_pkg::S_WALK;
      bldq_pkg::S_WALK: begin
        if (stat.walk_done) begin
          state_next = (stat.op == bldq_pkg::OP_SORT) ? bldq_pkg::S_FLUSH
                                                      : bldq_pkg::S_DONE;
        end
      end
      bldq_pkg::S_FLUSH: begin
        state_next = stat.last_pass ? bldq_pkg::S_DONE : bldq_pkg::S_SORT_START;
      end
      bldq_pkg::S_DONE: begin
        if (stat.out_free) state_next = bldq_pkg::S_IDLE;
      end
      default: state_next = bldq_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      bldq_pkg::S_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      bldq_pkg::S_DECODE: begin
        case (stat.op) inside
          bldq_pkg::OP_POP_FRONT, bldq_pkg::OP_POP_BACK: cmd.pop_read = !stat.empty;
          bldq_pkg::OP_DELETE, bldq_pkg::OP_CONTAINS:    cmd.walk_start = 1'b1;
          bldq_pkg::OP_SORT:                             cmd.sort_init = !stat.few;
          default: ;
        endcase
      end
      bldq_pkg::S_SORT_START: cmd.walk_start = 1'b1;
      bldq_pkg::S_WALK:       cmd.walk_run = 1'b1;
      bldq_pkg::S_FLUSH:      cmd.sort_flush = 1'b1;
      bldq_pkg::S_DONE:       cmd.result_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[rtl/bldq_dpath.sv]
// Datapath of the bounded list deque engine: circular word store, walk
// pipeline for delete, contains and bubble sort, and the result register.
// Depends on bldq_pkg.
`default_nettype none

module bldq_dpath #(
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire bldq_pkg::dp_cmd_t                   cmd,
  output bldq_pkg::dp_stat_t                       stat,
  input  wire logic [bldq_pkg::OP_W-1:0]           op,
  input  wire logic signed [bldq_pkg::WORD_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [bldq_pkg::WORD_W-1:0]       data_out,
  output logic [1:0]                               status,
  output logic                                     found,
  output logic [bldq_pkg::LEN_W-1:0]               length
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = bldq_pkg::WORD_W;

  // Word store, front of the list at head
  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] rd_data;
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr, wr_addr;
  logic [WW-1:0] wr_data;

  // List control
  logic [PW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;

  // Request
  bldq_pkg::op_t req_op;
  logic [WW-1:0] req_val;

  // Walk pipeline
  logic [CW-1:0] rd_idx, dat_idx, wr_idx, limit, pass_end;
  logic          rd_vld;
  logic [WW-1:0] carry;
  logic          hit;

  // Result
  logic [WW-1:0]     data_next;
  bldq_pkg::status_t status_next;
  logic              full, empty, issue, keep, gt;
  logic [CW+bldq_pkg::LEN_W-1:0] len_ext;

  // Logical index to physical address, one compare and subtract
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] base,
                                         input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(idx);
    if (sum >= (CW+1)'(DEPTH)) sum = sum - (CW+1)'(DEPTH);
    return sum[PW-1:0];
  endfunction

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign issue = cmd.walk_run && (rd_idx < limit);
  assign keep  = (rd_data != req_val);
  assign gt    = ($signed(carry) > $signed(rd_data));

  assign stat.op        = req_op;
  assign stat.empty     = empty;
  assign stat.few       = (count < CW'(2));
  assign stat.last_pass = (pass_end == CW'(1));
  assign stat.walk_done = !(rd_idx < limit) && !rd_vld;
  assign stat.out_free  = !out_valid || !out_stall;

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.pop_read) begin
      rd_en   = 1'b1;
      rd_addr = (req_op == bldq_pkg::OP_POP_FRONT) ? head : phys(head, count - CW'(1));
    end
    if (issue) begin
      rd_en   = 1'b1;
      rd_addr = phys(head, rd_idx);
    end
    if (cmd.walk_run && rd_vld) begin
      if (req_op == bldq_pkg::OP_DELETE && keep) begin
        wr_en   = 1'b1;
        wr_addr = phys(head, wr_idx);
        wr_data = rd_data;
      end
      // bubble step: smaller word drops back, larger stays in carry
      if (req_op == bldq_pkg::OP_SORT && dat_idx != '0) begin
        wr_en   = 1'b1;
        wr_addr = phys(head, dat_idx - CW'(1));
        wr_data = gt ? rd_data : carry;
      end
    end
    if (cmd.sort_flush) begin
      wr_en   = 1'b1;
      wr_addr = phys(head, pass_end);
      wr_data = carry;
    end
    if (cmd.result_load && !full) begin
      if (req_op == bldq_pkg::OP_PUSH_FRONT) begin
        wr_en   = 1'b1;
        wr_addr = head_next;
        wr_data = req_val;
      end else if (req_op == bldq_pkg::OP_PUSH_BACK) begin
        wr_en   = 1'b1;
        wr_addr = phys(head, count);
        wr_data = req_val;
      end
    end
  end

  // Store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // Commit values for the request at hand
  always_comb begin
    head_next   = head;
    count_next  = count;
    data_next   = '0;
    status_next = bldq_pkg::ST_OK;
    case (req_op)
      bldq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = bldq_pkg::ST_FULL;
        end else begin
          head_next  = (head == '0) ? PW'(DEPTH - 1) : head - PW'(1);
          count_next = count + CW'(1);
        end
      end
      bldq_pkg::OP_PUSH_BACK: begin
        if (full) status_next = bldq_pkg::ST_FULL;
        else      count_next  = count + CW'(1);
      end
      bldq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          data_next   = bldq_pkg::NEG_ONE;
          status_next = bldq_pkg::ST_EMPTY;
        end else begin
          data_next  = rd_data;
          head_next  = phys(head, CW'(1));
          count_next = count - CW'(1);
        end
      end
      bldq_pkg::OP_POP_BACK: begin
        if (empty) begin
          data_next   = bldq_pkg::NEG_ONE;
          status_next = bldq_pkg::ST_EMPTY;
        end else begin
          data_next  = rd_data;
          count_next = count - CW'(1);
        end
      end
      bldq_pkg::OP_DELETE: count_next = wr_idx;
      default: ;
    endcase
  end

  assign len_ext = (CW+bldq_pkg::LEN_W)'(count_next);

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.result_load) begin
        head  <= head_next;
        count <= count_next;
      end
      rd_vld <= issue;
      if (cmd.result_load)  out_valid <= 1'b1;
      else if (!out_stall)  out_valid <= 1'b0;
    end
  end

  // Request, walk and result payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op  <= bldq_pkg::op_t'(op);
      req_val <= value;
    end
    if (cmd.sort_init)  pass_end <= count - CW'(1);
    if (cmd.sort_flush) pass_end <= pass_end - CW'(1);
    if (cmd.walk_start) begin
      rd_idx <= '0;
      wr_idx <= '0;
      hit    <= 1'b0;
      limit  <= (req_op == bldq_pkg::OP_SORT) ? pass_end + CW'(1) : count;
    end
    if (issue) begin
      rd_idx  <= rd_idx + CW'(1);
      dat_idx <= rd_idx;
    end
    if (cmd.walk_run && rd_vld) begin
      if (req_op == bldq_pkg::OP_DELETE && keep) wr_idx <= wr_idx + CW'(1);
      if (req_op == bldq_pkg::OP_CONTAINS && !keep) hit <= 1'b1;
      if (req_op == bldq_pkg::OP_SORT && (dat_idx == '0 || !gt)) carry <= rd_data;
    end
    if (cmd.result_load) begin
      data_out <= $signed(data_next);
      status   <= status_next;
      found    <= (req_op == bldq_pkg::OP_CONTAINS) && hit;
      length   <= len_ext[bldq_pkg::LEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/bounded_list_deque_engine.sv]
// Top level of the deque engine: controller plus datapath. Depends on bldq_pkg,
// bldq_ctrl, bldq_dpath. Push, pop and no-op pass through decode to the result;
// delete and contains walk the list first, and sort runs bubble passes over it
// when it holds two entries or more. One request is taken at a time, the next
// only once the last result is loaded, which an output stall delays. Reset
// clears the length and front pointer, not the stored words.
`default_nettype none

module bounded_list_deque_engine #(
  parameter int DEPTH = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [bldq_pkg::OP_W-1:0]           op,
  input  wire logic signed [bldq_pkg::WORD_W-1:0]  value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [bldq_pkg::WORD_W-1:0]       data_out,
  output logic [1:0]                               status,
  output logic                                     found,
  output logic [bldq_pkg::LEN_W-1:0]               length
);

  bldq_pkg::dp_cmd_t  cmd;
  bldq_pkg::dp_stat_t stat;

  bldq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  bldq_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .op        (op),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out),
    .status    (status),
    .found     (found),
    .length    (length)
  );

endmodule

`default_nettype wire

[rtl/bldq_check.sv]
// Port-level checker for the bounded list deque engine, bound to the top level.
// Depends on bldq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module bldq_check #(
  parameter int DEPTH = 16
) (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                out_valid,
  input wire logic                                out_stall,
  input wire logic signed [bldq_pkg::WORD_W-1:0]  data_out,
  input wire logic [1:0]                          status,
  input wire logic                                found,
  input wire logic [bldq_pkg::LEN_W-1:0]          length
);

  // Length never beyond capacity (when it fits the field)
  `ASSERT_IMPLIES(a_len_cap, clk, rst, out_valid, (DEPTH > 31) || (length <= DEPTH))

  // Empty pop: -1 and nothing left
  `ASSERT_IMPLIES(a_empty_pop, clk, rst, out_valid && (status == bldq_pkg::ST_EMPTY), (data_out == -1) && (length == 0))

  // Refused push: list is at capacity and no data
  `ASSERT_IMPLIES(a_full_push, clk, rst, out_valid && (status == bldq_pkg::ST_FULL), (data_out == 0) && (length == bldq_pkg::LEN_W'(DEPTH)))

  // A hit comes only from a successful search
  `ASSERT_IMPLIES(a_found_ok, clk, rst, out_valid && found, (status == bldq_pkg::ST_OK) && (data_out == 0))

  // A stalled result holds
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(data_out) && $stable(length))

endmodule

bind bounded_list_deque_engine bldq_check #(.DEPTH(DEPTH)) u_bldq_check (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .data_out  (data_out),
  .status    (status),
  .found     (found),
  .length    (length)
);

`default_nettype wire
